@@ rtl/bmc_pkg.sv @@
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types and constants for the button multi-click decoder.
// ----------------------------------------------------------------------------
package bmc_pkg;

    localparam int unsigned TimeW  = 16;
    localparam int unsigned KindW  = 3;
    localparam int unsigned ClickW = 3;
    localparam int unsigned AddrW  = 3;
    localparam int unsigned MaxRes = 4;
    localparam int unsigned CntW   = 3;   // holds 0..MaxRes
    localparam int unsigned IdxW   = 2;   // indexes MaxRes slots

    localparam logic [TimeW-1:0] TimeSat = '1;

    // register reset values
    localparam logic [TimeW-1:0]  BounceMinRst  = 16'd30;
    localparam logic [TimeW-1:0]  ShortMaxRst   = 16'd500;
    localparam logic [TimeW-1:0]  ClickGapRst   = 16'd1000;
    localparam logic [ClickW-1:0] MaxClicksRst  = 3'd5;
    localparam logic [TimeW-1:0]  ListenHoldRst = 16'd3000;
    localparam logic [TimeW-1:0]  ExitMinRst    = 16'd3000;
    localparam logic [TimeW-1:0]  ExitMaxRst    = 16'd8000;
    localparam logic [TimeW-1:0]  ClearHoldRst  = 16'd10000;

    typedef enum logic [AddrW-1:0] {
        REG_BOUNCE_MIN  = 3'd0,
        REG_SHORT_MAX   = 3'd1,
        REG_CLICK_GAP   = 3'd2,
        REG_MAX_CLICKS  = 3'd3,
        REG_LISTEN_HOLD = 3'd4,
        REG_EXIT_MIN    = 3'd5,
        REG_EXIT_MAX    = 3'd6,
        REG_CLEAR_HOLD  = 3'd7
    } t_reg_idx;

    typedef enum logic [KindW-1:0] {
        EV_PRESS       = 3'd0,
        EV_RELEASE     = 3'd1,
        EV_CLICK       = 3'd2,
        EV_FINAL       = 3'd3,
        EV_ENTER_LISTEN = 3'd4,
        EV_EXIT_LISTEN = 3'd5,
        EV_CLEAR_CREDS = 3'd6
    } t_event_kind;

    typedef struct packed {
        logic [TimeW-1:0]  bounce_min_ms;
        logic [TimeW-1:0]  short_max_ms;
        logic [TimeW-1:0]  click_gap_ms;
        logic [ClickW-1:0] max_clicks;
        logic [TimeW-1:0]  listen_hold_ms;
        logic [TimeW-1:0]  exit_min_ms;
        logic [TimeW-1:0]  exit_max_ms;
        logic [TimeW-1:0]  clear_hold_ms;
    } t_cfg;

    // results of one tick, in order, n of them valid
    typedef struct packed {
        logic [CntW-1:0]               n;
        logic [MaxRes-1:0][KindW-1:0]  kind;
        logic [MaxRes-1:0][TimeW-1:0]  value;
    } t_bundle;

endpackage

@@ rtl/bmc_cfg.sv @@
// ----------------------------------------------------------------------------
// bmc_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module bmc_cfg
    import bmc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [AddrW-1:0] i_cfg_addr,
    input  logic [TimeW-1:0] i_cfg_wdata,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bounce_min_ms  <= BounceMinRst;
            r_cfg.short_max_ms   <= ShortMaxRst;
            r_cfg.click_gap_ms   <= ClickGapRst;
            r_cfg.max_clicks     <= MaxClicksRst;
            r_cfg.listen_hold_ms <= ListenHoldRst;
            r_cfg.exit_min_ms    <= ExitMinRst;
            r_cfg.exit_max_ms    <= ExitMaxRst;
            r_cfg.clear_hold_ms  <= ClearHoldRst;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_BOUNCE_MIN:  r_cfg.bounce_min_ms  <= i_cfg_wdata;
                REG_SHORT_MAX:   r_cfg.short_max_ms   <= i_cfg_wdata;
                REG_CLICK_GAP:   r_cfg.click_gap_ms   <= i_cfg_wdata;
                REG_MAX_CLICKS:  r_cfg.max_clicks     <= i_cfg_wdata[ClickW-1:0];
                REG_LISTEN_HOLD: r_cfg.listen_hold_ms <= i_cfg_wdata;
                REG_EXIT_MIN:    r_cfg.exit_min_ms    <= i_cfg_wdata;
                REG_EXIT_MAX:    r_cfg.exit_max_ms    <= i_cfg_wdata;
                REG_CLEAR_HOLD:  r_cfg.clear_hold_ms  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/bmc_core.sv @@
// ----------------------------------------------------------------------------
// bmc_core
// Press/hold/click state and the per-tick event decision.
// ----------------------------------------------------------------------------
module bmc_core
    import bmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_accept,
    input  logic    i_down,
    input  logic    i_lis,
    output t_bundle o_bundle
);

    localparam int unsigned NumCand = 5;

    logic              r_was_down, n_was_down;
    logic [TimeW-1:0]  r_hold, n_hold;
    logic              r_lap, n_lap;
    logic [ClickW-1:0] r_count, n_count;
    logic              r_armed, n_armed;
    logic [TimeW-1:0]  r_gap, n_gap;
    logic              r_creds, n_creds;

    // candidate slots: 0 edge/hold event, 1 click, 2 classify final,
    // 3 listen request, 4 gap final
    logic [NumCand-1:0]              cand_en;
    logic [NumCand-1:0][KindW-1:0]   cand_kind;
    logic [NumCand-1:0][TimeW-1:0]   cand_val;

    logic              do_class;
    logic [TimeW-1:0]  d;
    logic [TimeW-1:0]  hold_inc;
    logic [ClickW-1:0] cnt1;
    logic [CntW-1:0]   k;
    t_bundle           bundle;

    always_comb begin
        n_was_down = i_down;
        n_lap      = r_lap;
        n_count    = r_count;
        n_armed    = r_armed;
        n_gap      = r_gap;
        n_creds    = r_creds;
        cand_en    = '0;
        cand_kind  = '0;
        cand_val   = '0;
        do_class   = 1'b0;
        cnt1       = r_count + 1'b1;

        hold_inc = (r_was_down && r_hold != TimeSat) ? r_hold + 1'b1 : r_hold;
        n_hold   = hold_inc;
        d        = hold_inc;

        if (i_down && !r_was_down) begin
            n_lap   = i_lis;
            n_hold  = '0;
            n_creds = 1'b0;
            cand_en[0]   = !i_lis;
            cand_kind[0] = EV_PRESS;
        end else if (!i_down && r_was_down) begin
            if (!i_lis) begin
                cand_en[0]   = 1'b1;
                cand_kind[0] = EV_RELEASE;
                cand_val[0]  = d;
                do_class     = 1'b1;
            end
            cand_en[3]   = (d > i_cfg.exit_min_ms) && (d < i_cfg.exit_max_ms) && r_lap && i_lis;
            cand_kind[3] = EV_EXIT_LISTEN;
            n_hold = '0;
        end else if (i_down && r_was_down) begin
            if (i_lis && hold_inc >= i_cfg.clear_hold_ms && !r_creds) begin
                n_creds      = 1'b1;
                cand_en[0]   = 1'b1;
                cand_kind[0] = EV_CLEAR_CREDS;
            end else if (!i_lis && hold_inc >= i_cfg.listen_hold_ms && !r_lap) begin
                cand_en[0]   = 1'b1;
                cand_kind[0] = EV_RELEASE;
                cand_val[0]  = d;
                do_class     = 1'b1;
                cand_en[3]   = 1'b1;
                cand_kind[3] = EV_ENTER_LISTEN;
                n_lap   = 1'b1;
                n_hold  = '0;
                n_creds = 1'b0;
            end
        end

        cand_kind[1] = EV_CLICK;
        cand_kind[2] = EV_FINAL;
        if (do_class && d >= i_cfg.bounce_min_ms) begin
            if (d < i_cfg.short_max_ms) begin
                cand_en[1]  = 1'b1;
                cand_val[1] = TimeW'(cnt1);
                if (cnt1 < i_cfg.max_clicks) begin
                    n_count = cnt1;
                    n_armed = 1'b1;
                    n_gap   = '0;
                end else begin
                    n_count     = '0;
                    n_armed     = 1'b0;
                    n_gap       = '0;
                    cand_en[2]  = (cnt1 != '0);
                    cand_val[2] = TimeW'(cnt1);
                end
            end else begin
                n_count     = '0;
                n_armed     = 1'b0;
                n_gap       = '0;
                cand_en[2]  = (r_count != '0);
                cand_val[2] = TimeW'(r_count);
            end
        end

        cand_kind[4] = EV_FINAL;
        if (n_armed) begin
            if (n_gap > i_cfg.click_gap_ms) begin
                cand_en[4]  = (n_count != '0);
                cand_val[4] = TimeW'(n_count);
                n_count = '0;
                n_armed = 1'b0;
                n_gap   = '0;
            end else if (n_gap != TimeSat) begin
                n_gap = n_gap + 1'b1;
            end
        end
    end

    // pack enabled candidates in order, at most MaxRes
    always_comb begin
        bundle = '0;
        k      = '0;
        for (int i = 0; i < NumCand; i++) begin
            if (cand_en[i] && k < CntW'(MaxRes)) begin
                bundle.kind[k[IdxW-1:0]]  = cand_kind[i];
                bundle.value[k[IdxW-1:0]] = cand_val[i];
                k = k + 1'b1;
            end
        end
        bundle.n = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_down <= 1'b0;
            r_hold     <= '0;
            r_lap      <= 1'b0;
            r_count    <= '0;
            r_armed    <= 1'b0;
            r_gap      <= '0;
            r_creds    <= 1'b0;
        end else if (i_accept) begin
            r_was_down <= n_was_down;
            r_hold     <= n_hold;
            r_lap      <= n_lap;
            r_count    <= n_count;
            r_armed    <= n_armed;
            r_gap      <= n_gap;
            r_creds    <= n_creds;
        end
    end

    assign o_bundle = bundle;

endmodule

@@ rtl/bmc_out.sv @@
// ----------------------------------------------------------------------------
// bmc_out
// Result register: holds one tick's events and sends them one beat each.
// ----------------------------------------------------------------------------
module bmc_out
    import bmc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_bundle          i_bundle,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [KindW-1:0] o_kind,
    output logic [TimeW-1:0] o_value,
    output logic             o_last
);

    logic                          r_valid;
    logic [IdxW-1:0]               r_idx;
    logic [CntW-1:0]               r_n;
    logic [MaxRes-1:0][KindW-1:0]  r_kind;
    logic [MaxRes-1:0][TimeW-1:0]  r_value;
    logic                          last;

    assign last   = (CntW'(r_idx) + 1'b1) == r_n;
    assign o_free = !r_valid || (i_ready && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_ready) begin
            if (last) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_n     <= i_bundle.n;
            r_kind  <= i_bundle.kind;
            r_value <= i_bundle.value;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind[r_idx];
    assign o_value = r_value[r_idx];
    assign o_last  = last;

endmodule

@@ rtl/button_multi_click_decoder.sv @@
// ----------------------------------------------------------------------------
// button_multi_click_decoder
// Millisecond-tick button decoder: press, release, clicks, long-press requests.
// ----------------------------------------------------------------------------
// One input beat per tick. Each tick is decided in the cycle it is accepted
// and yields zero to four event beats, held in the result register and sent
// one per cycle while m_axis_tready is high; tlast marks the tick's final
// event. A tick giving no events leaves the output free for the next tick;
// otherwise the next tick is taken in the cycle its last beat leaves. The
// output register's drain is what sets the rate.
module button_multi_click_decoder
    import bmc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config
    input  logic             i_cfg_we,
    input  logic [AddrW-1:0] i_cfg_addr,
    input  logic [TimeW-1:0] i_cfg_wdata,
    // tick in
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [0] button_down, [1] listening
    // events out
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [2:0] event_kind, [18:3] event_value
    output logic             m_axis_tlast    // last_event
);

    t_cfg             cfg;
    t_bundle          bundle;
    logic             accept;
    logic             free;
    logic [KindW-1:0] kind;
    logic [TimeW-1:0] value;

    bmc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign s_axis_tready = free;
    assign accept        = s_axis_tvalid && free;

    bmc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_down   (s_axis_tdata[0]),
        .i_lis    (s_axis_tdata[1]),
        .o_bundle (bundle)
    );

    bmc_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && (bundle.n != '0)),
        .i_bundle (bundle),
        .o_free   (free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_kind   (kind),
        .o_value  (value),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, value, kind};

endmodule

@@ dv/tb_button_multi_click_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_button_multi_click_decoder
// Self-checking bench for the button multi-click decoder.
// ----------------------------------------------------------------------------
// Ticks queued by the stimulus block are driven as input beats by a clocked
// driver. Every accepted tick runs through a local model of the decoder,
// which queues the event beats it should cause. A clocked monitor checks
// each output beat against the oldest queued event. Registers are changed
// only with the decoder drained. The run covers the reset settings, scaled
// down settings that reach every long-press request, several extreme
// settings with random press sequences, a click limit lowered mid-sequence
// and the largest click gap.
// ----------------------------------------------------------------------------
module tb_button_multi_click_decoder;
    import bmc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned StallLimit = 2000;

    typedef struct {
        logic [KindW-1:0] kind;
        logic [TimeW-1:0] value;
        logic             last;
    } t_event_beat;

    logic             i_clk;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [AddrW-1:0] i_cfg_addr    = '0;
    logic [TimeW-1:0] i_cfg_wdata   = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;   // [0] button_down, [1] listening
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [23:0]      m_axis_tdata;         // [2:0] event_kind, [18:3] event_value
    logic             m_axis_tlast;         // last_event

    button_multi_click_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ticks still to send, {listening, button_down}
    logic [1:0]  tick_q[$];
    t_event_beat pending_events[$];
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;
    logic        no_idle = 1'b0;

    // decoder model
    t_cfg cfg = '{
        bounce_min_ms:  BounceMinRst,
        short_max_ms:   ShortMaxRst,
        click_gap_ms:   ClickGapRst,
        max_clicks:     MaxClicksRst,
        listen_hold_ms: ListenHoldRst,
        exit_min_ms:    ExitMinRst,
        exit_max_ms:    ExitMaxRst,
        clear_hold_ms:  ClearHoldRst
    };
    logic              btn_was_down    = 1'b0;
    logic [TimeW-1:0]  hold_time       = '0;
    logic              press_in_listen = 1'b0;
    logic [ClickW-1:0] clicks          = '0;
    logic              gap_on          = 1'b0;
    logic [TimeW-1:0]  gap_time        = '0;
    logic              creds_done      = 1'b0;

    logic [KindW-1:0]  tick_kind[MaxRes];
    logic [TimeW-1:0]  tick_value[MaxRes];
    int unsigned       tick_events;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void note_event(t_event_kind kind, logic [TimeW-1:0] value);
        if (tick_events < MaxRes) begin
            tick_kind[tick_events]  = kind;
            tick_value[tick_events] = value;
            tick_events++;
        end
    endfunction

    function automatic void close_sequence();
        logic [ClickW-1:0] count;
        count    = clicks;
        clicks   = '0;
        gap_on   = 1'b0;
        gap_time = '0;
        if (count != 0) note_event(EV_FINAL, TimeW'(count));
    endfunction

    function automatic void rate_hold(logic [TimeW-1:0] held);
        if (held < cfg.bounce_min_ms) return;
        if (held < cfg.short_max_ms) begin
            clicks = clicks + 1'b1;
            note_event(EV_CLICK, TimeW'(clicks));
            if (clicks < cfg.max_clicks) begin
                gap_on   = 1'b1;
                gap_time = '0;
                return;
            end
        end
        close_sequence();
    endfunction

    function automatic void decode_tick(logic down, logic lis);
        tick_events = 0;
        if (btn_was_down && hold_time != TimeSat) hold_time = hold_time + 1'b1;

        if (down && !btn_was_down) begin
            press_in_listen = lis;
            hold_time       = '0;
            creds_done      = 1'b0;
            if (!lis) note_event(EV_PRESS, '0);
        end else if (!down && btn_was_down) begin
            if (!lis) begin
                note_event(EV_RELEASE, hold_time);
                rate_hold(hold_time);
            end
            if (hold_time > cfg.exit_min_ms && hold_time < cfg.exit_max_ms
                && press_in_listen && lis) begin
                note_event(EV_EXIT_LISTEN, '0);
            end
            hold_time = '0;
        end else if (down && btn_was_down) begin
            if (lis && hold_time >= cfg.clear_hold_ms && !creds_done) begin
                creds_done = 1'b1;
                note_event(EV_CLEAR_CREDS, '0);
            end else if (!lis && hold_time >= cfg.listen_hold_ms && !press_in_listen) begin
                note_event(EV_RELEASE, hold_time);
                rate_hold(hold_time);
                note_event(EV_ENTER_LISTEN, '0);
                press_in_listen = 1'b1;
                hold_time       = '0;
                creds_done      = 1'b0;
            end
        end

        if (gap_on) begin
            if (gap_time > cfg.click_gap_ms) close_sequence();
            else if (gap_time != TimeSat) gap_time = gap_time + 1'b1;
        end
        btn_was_down = down;

        for (int unsigned i = 0; i < tick_events; i++) begin
            pending_events.push_back('{tick_kind[i], tick_value[i], i == tick_events - 1});
        end
    endfunction

    function automatic void check_event();
        t_event_beat      want;
        logic [KindW-1:0] got_kind;
        logic [TimeW-1:0] got_value;
        got_kind  = m_axis_tdata[KindW-1:0];
        got_value = m_axis_tdata[KindW +: TimeW];
        if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected event kind %0d value %0d last %0b",
                         $realtime, got_kind, got_value, m_axis_tlast);
        end else begin
            want = pending_events.pop_front();
            if (want.kind !== got_kind || want.value !== got_value
                || want.last !== m_axis_tlast) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: event mismatch, expected kind %0d value %0d last %0b,",
                              " got kind %0d value %0d last %0b"},
                             $realtime, want.kind, want.value, want.last,
                             got_kind, got_value, m_axis_tlast);
            end
        end
    endfunction

    // tick driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (tick_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 12)) begin
                s_axis_tdata  <= {6'd0, tick_q.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // event sink back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || $urandom_range(0, 99) >= 12;
        end
    end

    // monitor: model first, so a same-cycle event could still find its entry
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) decode_tick(s_axis_tdata[0], s_axis_tdata[1]);
            if (m_axis_tvalid && m_axis_tready) check_event();
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (tick_q.size() == 0 && !s_axis_tvalid && pending_events.size() == 0)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= StallLimit) begin
            $display("%0t: no beat moved for %0d cycles", $realtime, StallLimit);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic cfg_write(t_reg_idx idx, logic [TimeW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_BOUNCE_MIN:  cfg.bounce_min_ms  = val;
            REG_SHORT_MAX:   cfg.short_max_ms   = val;
            REG_CLICK_GAP:   cfg.click_gap_ms   = val;
            REG_MAX_CLICKS:  cfg.max_clicks     = val[ClickW-1:0];
            REG_LISTEN_HOLD: cfg.listen_hold_ms = val;
            REG_EXIT_MIN:    cfg.exit_min_ms    = val;
            REG_EXIT_MAX:    cfg.exit_max_ms    = val;
            REG_CLEAR_HOLD:  cfg.clear_hold_ms  = val;
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [TimeW-1:0] bounce, logic [TimeW-1:0] short_max,
                           logic [TimeW-1:0] gap, logic [TimeW-1:0] max_clk,
                           logic [TimeW-1:0] listen, logic [TimeW-1:0] exit_min,
                           logic [TimeW-1:0] exit_max, logic [TimeW-1:0] clear);
        cfg_write(REG_BOUNCE_MIN, bounce);
        cfg_write(REG_SHORT_MAX, short_max);
        cfg_write(REG_CLICK_GAP, gap);
        cfg_write(REG_MAX_CLICKS, max_clk);
        cfg_write(REG_LISTEN_HOLD, listen);
        cfg_write(REG_EXIT_MIN, exit_min);
        cfg_write(REG_EXIT_MAX, exit_max);
        cfg_write(REG_CLEAR_HOLD, clear);
    endtask

    // wait for the decoder to drain
    task automatic drain();
        while (tick_q.size() != 0 || s_axis_tvalid || pending_events.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_ticks(logic down, logic lis, int unsigned n);
        repeat (n) tick_q.push_back({lis, down});
    endtask

    // press held for len ticks; listening is lis_a for the first split ticks,
    // lis_b afterwards, on release and through the idle gap
    task automatic add_press(logic lis_a, logic lis_b, int unsigned len,
                             int unsigned split, int unsigned gap);
        for (int unsigned i = 0; i < len; i++) tick_q.push_back({i < split ? lis_a : lis_b, 1'b1});
        add_ticks(1'b0, lis_b, gap + 1);
    endtask

    task automatic add_random(int unsigned n);
        int unsigned added;
        int unsigned len;
        int unsigned gap;
        int unsigned split;
        logic        lis;
        added = 0;
        while (added < n) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 4);
                repeat (len) tick_q.push_back(2'($urandom_range(0, 3)));
                added += len;
            end else begin
                lis   = ($urandom_range(0, 3) == 0);
                len   = $urandom_range(1, 32);
                gap   = $urandom_range(0, 12);
                split = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len) : len;
                add_press(lis, split == len ? lis : !lis, len, split, gap);
                added += len + gap + 1;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings
        add_ticks(1'b0, 1'b0, 3);
        add_press(1'b0, 1'b0, 10, 10, 5);        // bounce
        add_press(1'b0, 1'b0, 30, 30, 2);        // shortest click
        drain();

        // scaled down settings reaching every request
        cfg_all(16'd2, 16'd6, 16'd8, 16'd3, 16'd12, 16'd4, 16'd9, 16'd8);
        add_press(1'b0, 1'b0, 5, 5, 10);         // longest click, then gap ends it
        add_press(1'b0, 1'b0, 6, 6, 2);          // shortest long press
        add_ticks(1'b1, 1'b0, 13);               // enter listening
        add_ticks(1'b1, 1'b1, 10);               // clear credentials
        add_ticks(1'b0, 1'b1, 2);
        add_press(1'b1, 1'b1, 7, 7, 2);          // exit listening
        drain();

        cfg_all(16'd2, 16'd6, 16'd8, 16'd3, 16'd20, 16'd10, 16'd18, 16'd25);
        add_random(12);
        drain();

        no_idle = 1'b1;
        cfg_all(16'd0, 16'hFFFF, 16'd0, 16'd7, 16'd12, 16'd0, 16'hFFFF, 16'd0);
        add_random(12);
        drain();
        no_idle = 1'b0;

        cfg_all(16'hFFFF, 16'd0, 16'd4, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        add_random(8);
        drain();
        cfg_all(16'd1, 16'd8, 16'd4, 16'd0, 16'd40, 16'd3, 16'd9, 16'd50);
        add_random(8);
        drain();

        // click limit lowered mid-sequence, then the largest gap
        cfg_all(16'd1, 16'd8, 16'd30, 16'd7, 16'd40, 16'd5, 16'd60, 16'd50);
        repeat (4) add_press(1'b0, 1'b0, 3, 3, 2);
        drain();
        cfg_write(REG_MAX_CLICKS, 16'hFFF8 | 16'd2);
        add_press(1'b0, 1'b0, 3, 3, 2);
        drain();
        cfg_write(REG_MAX_CLICKS, 16'd3);
        cfg_write(REG_CLICK_GAP, 16'hFFFF);
        add_press(1'b0, 1'b0, 3, 3, 4);
        add_press(1'b0, 1'b0, 3, 3, 4);
        add_press(1'b0, 1'b0, 10, 10, 3);
        drain();
        cfg_write(REG_CLICK_GAP, 16'd0);
        add_press(1'b0, 1'b0, 3, 3, 3);
        drain();
        cfg_write(REG_CLICK_GAP, 16'd6);
        add_random(8);
        drain();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
